// ===== rtl/stacked_max_priority_queue_assert.svh =====
`ifndef STACKED_MAX_PRIORITY_QUEUE_ASSERT_SVH
`define STACKED_MAX_PRIORITY_QUEUE_ASSERT_SVH

// Invariant that must hold at every clock edge outside reset
`define SMPQ_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Same-cycle implication
`define SMPQ_IMPLY(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication
`define SMPQ_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== rtl/smpq_pkg.sv =====
package smpq_pkg;

   // command codes carried in req_tuser
   typedef enum logic [2:0] {
      CMD_PUSH = 3'd0,
      CMD_POP  = 3'd1,
      CMD_ENQ  = 3'd2,
      CMD_DEQ  = 3'd3,
      CMD_SET  = 3'd4
   } cmd_type;

   // status codes carried in rsp_tuser
   typedef enum logic [2:0] {
      STAT_OK          = 3'd0,
      STAT_STACK_FULL  = 3'd1,
      STAT_STACK_EMPTY = 3'd2,
      STAT_QUEUE_FULL  = 3'd3,
      STAT_QUEUE_EMPTY = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_FIX
   } state_type;

   // one queue entry
   typedef struct packed {
      logic [15:0]        move;
      logic signed [31:0] score;
   } entry_type;

   // preferred move with its valid flag in the top bit
   typedef struct packed {
      logic        valid;
      logic [15:0] move;
   } pref_type;

   // starting best score of a scan
   localparam logic signed [31:0] SCORE_FLOOR = 32'sh8000_0001;

endpackage

// ===== rtl/smpq_entry_store.sv =====
module smpq_entry_store
   import smpq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 256,
   parameter int ADDR_W      = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  entry_type         wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output entry_type         rd_data
);

   entry_type mem [QUEUE_DEPTH];
   entry_type rd_data_ff;

   // write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/smpq_frame_stack.sv =====
module smpq_frame_stack
   import smpq_pkg::*;
#(
   parameter int STACK_DEPTH = 64,
   parameter int ADDR_W      = 6,
   parameter int START_W     = 9
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [START_W-1:0] wr_start,
   input  pref_type           wr_pref,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [START_W-1:0] rd_start,
   output pref_type           rd_pref
);

   logic [START_W-1:0] start_mem [STACK_DEPTH];
   pref_type           pref_mem  [STACK_DEPTH];
   logic [START_W-1:0] rd_start_ff;
   pref_type           rd_pref_ff;

   // save one frame
   always_ff @(posedge clock) begin
      if (wr_en) begin
         start_mem[wr_addr] <= wr_start;
         pref_mem[wr_addr]  <= wr_pref;
      end
   end

   // registered read of the level below the top
   always_ff @(posedge clock) begin
      rd_start_ff <= start_mem[rd_addr];
      rd_pref_ff  <= pref_mem[rd_addr];
   end

   assign rd_start = rd_start_ff;
   assign rd_pref  = rd_pref_ff;

endmodule

// ===== rtl/stacked_max_priority_queue.sv =====
// channel  dir  tvalid/tready           tdata (low bit up)                 tuser (low bit up)
// req      in   req_tvalid/req_tready   move[15:0] score[47:16]            cmd[2:0]
// rsp      out  rsp_tvalid/rsp_tready   out_move[15:0] is_empty[16] pad    move_valid[0] status[3:1]
//
// Push, pop, enqueue, set-preferred and a served or empty dequeue pass through IDLE and EXEC.
// A scanning dequeue reads the N entries of its frame in turn: the entry store has one
// read port and yields one score per cycle, then the FIX state writes the last entry back.
// Reset is synchronous and clears the frame pointers, stack level and preferred move;
// the entry and frame stores need no clearing.
// A new word is taken while a result waits; a stalled rsp channel holds the next result.
module stacked_max_priority_queue
   import smpq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 256,
   parameter int STACK_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // move[15:0], score[47:16]
   input  logic [2:0]  req_tuser,   // cmd[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // out_move[15:0], is_empty[16], zero[23:17]
   output logic [3:0]  rsp_tuser    // move_valid[0], status[3:1]
);

`include "stacked_max_priority_queue_assert.svh"

   localparam int QW = $clog2(QUEUE_DEPTH + 1);
   localparam int QI = $clog2(QUEUE_DEPTH);
   localparam int SW = $clog2(STACK_DEPTH + 1);
   localparam int SI = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam logic [QW-1:0] QDEPTH_Q = QW'(QUEUE_DEPTH);
   localparam logic [SW-1:0] SDEPTH_S = SW'(STACK_DEPTH);

   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [15:0]        move_ff, move_in;
   logic signed [31:0] score_ff, score_in;

   logic [QW-1:0]      frame_start_ff, frame_start_in;
   logic [QW-1:0]      frame_end_ff, frame_end_in;
   logic [SW-1:0]      level_ff, level_in;
   pref_type           pref_ff, pref_in;

   logic [QW-1:0]      issue_ff, issue_in;
   logic               rv_ff, rv_in;
   logic [QW-1:0]      ridx_ff, ridx_in;
   logic [QW-1:0]      best_idx_ff, best_idx_in;
   logic signed [31:0] best_score_ff, best_score_in;
   logic [15:0]        best_move_ff, best_move_in;
   entry_type          last_ff, last_in;

   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [15:0]        rsp_move_ff, rsp_move_in;
   logic               rsp_mv_ff, rsp_mv_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic               rsp_empty_ff, rsp_empty_in;

   logic               out_free;
   logic               done;
   logic [15:0]        res_move;
   logic               res_valid;
   status_type         res_status;
   logic [QW-1:0]      last_idx;
   logic [SW-1:0]      level_dn;

   logic               ent_wr_en;
   logic [QI-1:0]      ent_wr_addr;
   entry_type          ent_wr_data;
   entry_type          ent_rd_data;
   logic               stk_wr_en;
   logic [QW-1:0]      stk_rd_start;
   pref_type           stk_rd_pref;

   smpq_entry_store #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ADDR_W      (QI)
   ) u_entry_store (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (ent_wr_addr),
      .wr_data (ent_wr_data),
      .rd_addr (issue_ff[QI-1:0]),
      .rd_data (ent_rd_data)
   );

   smpq_frame_stack #(
      .STACK_DEPTH (STACK_DEPTH),
      .ADDR_W      (SI),
      .START_W     (QW)
   ) u_frame_stack (
      .clock    (clock),
      .wr_en    (stk_wr_en),
      .wr_addr  (level_ff[SI-1:0]),
      .wr_start (frame_start_ff),
      .wr_pref  (pref_ff),
      .rd_addr  (level_dn[SI-1:0]),
      .rd_start (stk_rd_start),
      .rd_pref  (stk_rd_pref)
   );

   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign last_idx = frame_end_ff - 1'b1;
   assign level_dn = level_ff - 1'b1;

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         frame_start_ff <= '0;
         frame_end_ff   <= '0;
         level_ff       <= '0;
         pref_ff        <= '0;
         rv_ff          <= 1'b0;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         frame_start_ff <= frame_start_in;
         frame_end_ff   <= frame_end_in;
         level_ff       <= level_in;
         pref_ff        <= pref_in;
         rv_ff          <= rv_in;
         rsp_tvalid_ff  <= rsp_tvalid_in;
      end
   end

   // payload and scan registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      move_ff       <= move_in;
      score_ff      <= score_in;
      issue_ff      <= issue_in;
      ridx_ff       <= ridx_in;
      best_idx_ff   <= best_idx_in;
      best_score_ff <= best_score_in;
      best_move_ff  <= best_move_in;
      last_ff       <= last_in;
      rsp_move_ff   <= rsp_move_in;
      rsp_mv_ff     <= rsp_mv_in;
      rsp_status_ff <= rsp_status_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   // next state and outputs
   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      move_in        = move_ff;
      score_in       = score_ff;
      frame_start_in = frame_start_ff;
      frame_end_in   = frame_end_ff;
      level_in       = level_ff;
      pref_in        = pref_ff;
      issue_in       = issue_ff;
      rv_in          = rv_ff;
      ridx_in        = ridx_ff;
      best_idx_in    = best_idx_ff;
      best_score_in  = best_score_ff;
      best_move_in   = best_move_ff;
      last_in        = last_ff;
      rsp_tvalid_in  = rsp_tvalid_ff && !rsp_tready;
      rsp_move_in    = rsp_move_ff;
      rsp_mv_in      = rsp_mv_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_empty_in   = rsp_empty_ff;
      ent_wr_en      = 1'b0;
      ent_wr_addr    = frame_end_ff[QI-1:0];
      ent_wr_data    = '{move: move_ff, score: score_ff};
      stk_wr_en      = 1'b0;
      req_tready     = 1'b0;
      done           = 1'b0;
      res_move       = '0;
      res_valid      = 1'b0;
      res_status     = STAT_OK;

      case (state_ff)
         ST_IDLE: begin
            // take the next word
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd_in   = cmd_type'(req_tuser);
               move_in  = req_tdata[15:0];
               score_in = $signed(req_tdata[47:16]);
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            case (cmd_ff)
               CMD_PUSH: begin
                  done = 1'b1;
                  if (level_ff == SDEPTH_S) begin
                     res_status = STAT_STACK_FULL;
                  end else if (out_free) begin
                     stk_wr_en      = 1'b1;
                     level_in       = level_ff + 1'b1;
                     frame_start_in = frame_end_ff;
                     pref_in        = '0;
                  end
               end
               CMD_POP: begin
                  // restore from the registered read of the level below
                  done = 1'b1;
                  if (level_ff == '0) begin
                     res_status = STAT_STACK_EMPTY;
                  end else if (out_free) begin
                     level_in       = level_dn;
                     frame_end_in   = frame_start_ff;
                     frame_start_in = stk_rd_start;
                     pref_in        = stk_rd_pref;
                  end
               end
               CMD_ENQ: begin
                  done = 1'b1;
                  if (frame_end_ff == QDEPTH_Q) begin
                     res_status = STAT_QUEUE_FULL;
                  end else if (!(pref_ff.valid && move_ff == pref_ff.move) && out_free) begin
                     ent_wr_en    = 1'b1;
                     frame_end_in = frame_end_ff + 1'b1;
                  end
               end
               CMD_DEQ: begin
                  if (pref_ff.valid) begin
                     done      = 1'b1;
                     res_move  = pref_ff.move;
                     res_valid = 1'b1;
                     if (out_free) begin
                        pref_in = '0;
                     end
                  end else if (frame_end_ff == frame_start_ff) begin
                     done       = 1'b1;
                     res_status = STAT_QUEUE_EMPTY;
                  end else begin
                     // start the scan at the frame base
                     state_in      = ST_SCAN;
                     issue_in      = frame_start_ff;
                     rv_in         = 1'b0;
                     best_idx_in   = frame_start_ff;
                     best_score_in = SCORE_FLOOR;
                  end
               end
               CMD_SET: begin
                  done = 1'b1;
                  if (out_free) begin
                     pref_in = '{valid: 1'b1, move: move_ff};
                  end
               end
               default: begin
                  done = 1'b1;
               end
            endcase
         end

         ST_SCAN: begin
            // issue one read per cycle up to the frame end
            if (issue_ff != frame_end_ff) begin
               issue_in = issue_ff + 1'b1;
               rv_in    = 1'b1;
               ridx_in  = issue_ff;
            end else begin
               rv_in = 1'b0;
            end
            // compare the returning entry against the best so far
            if (rv_ff) begin
               if (ridx_ff == frame_start_ff) begin
                  best_move_in = ent_rd_data.move;
                  if ($signed(ent_rd_data.score) > SCORE_FLOOR) begin
                     best_score_in = ent_rd_data.score;
                  end
               end else if ($signed(ent_rd_data.score) > best_score_ff) begin
                  best_idx_in   = ridx_ff;
                  best_score_in = ent_rd_data.score;
                  best_move_in  = ent_rd_data.move;
               end
               if (ridx_ff == last_idx) begin
                  last_in  = ent_rd_data;
                  state_in = ST_FIX;
               end
            end
         end

         ST_FIX: begin
            // fill the served slot with the last entry
            done        = 1'b1;
            res_move    = best_move_ff;
            res_valid   = 1'b1;
            ent_wr_en   = out_free;
            ent_wr_addr = best_idx_ff[QI-1:0];
            ent_wr_data = last_ff;
            if (out_free) begin
               frame_end_in = last_idx;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // load the result register
      if (done && out_free) begin
         rsp_tvalid_in = 1'b1;
         rsp_move_in   = res_move;
         rsp_mv_in     = res_valid;
         rsp_status_in = res_status;
         rsp_empty_in  = !pref_in.valid && (frame_end_in == frame_start_in);
         state_in      = ST_IDLE;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {7'b0, rsp_empty_ff, rsp_move_ff};
   assign rsp_tuser  = {rsp_status_ff, rsp_mv_ff};

   `SMPQ_ALWAYS(a_frame_order, frame_start_ff <= frame_end_ff, "frame start passed frame end")
   `SMPQ_ALWAYS(a_frame_bound, frame_end_ff <= QDEPTH_Q, "frame end beyond queue depth")
   `SMPQ_ALWAYS(a_level_bound, level_ff <= SDEPTH_S, "stack level beyond stack depth")
   `SMPQ_IMPLY(a_fix_in_frame, state_ff == ST_FIX,
      (best_idx_ff >= frame_start_ff) && (best_idx_ff < frame_end_ff),
      "served slot outside the frame")
   `SMPQ_NEXT(a_accept_exec, req_tvalid && req_tready, state_ff == ST_EXEC,
      "accepted word did not start execution")

endmodule
